### hdl/tlps_pkg.sv
package tlps_pkg;

    // phase codes
    localparam logic [2:0] PH_GREEN1 = 3'd0;
    localparam logic [2:0] PH_YELRED = 3'd1;
    localparam logic [2:0] PH_RED    = 3'd2;
    localparam logic [2:0] PH_PED    = 3'd3;
    localparam logic [2:0] PH_YELLOW = 3'd4;
    localparam logic [2:0] PH_GREEN2 = 3'd5;

    // register indexes
    localparam logic [2:0] REG_GREEN_TICKS     = 3'd0;
    localparam logic [2:0] REG_YELLOW_TICKS    = 3'd1;
    localparam logic [2:0] REG_RED_TICKS       = 3'd2;
    localparam logic [2:0] REG_BUZZ_HALF_TICKS = 3'd3;
    localparam logic [2:0] REG_BUZZ_CYCLES     = 3'd4;

    // register reset values
    localparam logic [15:0] GREEN_TICKS_RST     = 16'd100;
    localparam logic [15:0] YELLOW_TICKS_RST    = 16'd40;
    localparam logic [15:0] RED_TICKS_RST       = 16'd100;
    localparam logic [15:0] BUZZ_HALF_TICKS_RST = 16'd10;
    localparam logic [7:0]  BUZZ_CYCLES_RST     = 8'd10;

    typedef struct packed {
        logic [15:0] green_ticks;
        logic [15:0] yellow_ticks;
        logic [15:0] red_ticks;
        logic [15:0] buzz_half_ticks;
        logic [7:0]  buzz_cycles;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] tick_count;
        logic [8:0]  half_count;
        logic        button_was_down;
        logic        request;
    } state_t;

    typedef struct packed {
        logic       red_lamp;
        logic       yellow_lamp;
        logic       green_lamp;
        logic       buzzer_drive;
        logic       walk_pending;
        logic [2:0] phase_now;
    } result_t;

    // zero duration counts as one tick
    function automatic logic [15:0] at_least_one16(input logic [15:0] v);
        at_least_one16 = (v == 16'd0) ? 16'd1 : v;
    endfunction

    function automatic logic [7:0] at_least_one8(input logic [7:0] v);
        at_least_one8 = (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

### hdl/traffic_light_pedestrian_sequencer_unit.sv
// channel   signals                                   direction
// --------  ----------------------------------------  ---------
// tick in   in_valid, in_ready, button_down           in
// lamps out out_valid, out_ready, red_lamp,           out
//           yellow_lamp, green_lamp, buzzer_drive,
//           walk_pending, phase_now
// config    cfg_write, cfg_index, cfg_data            in
//
// one tick transaction per cycle while the output is not stalled; the result appears in the cycle after accept
// the phase state and the result register update in the same cycle
// in_ready is high while the result register is empty or being drained
// an output stall holds the result and blocks new ticks until it is taken
// reset returns to green1 with counters and request cleared, registers to defaults
module traffic_light_pedestrian_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        button_down,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        red_lamp,
    output logic        yellow_lamp,
    output logic        green_lamp,
    output logic        buzzer_drive,
    output logic        walk_pending,
    output logic [2:0]  phase_now,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tlps_pkg::cfg_t    cfg;
    tlps_pkg::state_t  state_reg;
    tlps_pkg::state_t  state_next;
    tlps_pkg::result_t result_reg;
    tlps_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              accept;

    tlps_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlps_step_logic u_step_logic (
        .cfg         (cfg),
        .state       (state_reg),
        .button_down (button_down),
        .state_next  (state_next),
        .result      (result_next)
    );

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_lamp     = result_reg.red_lamp;
    assign yellow_lamp  = result_reg.yellow_lamp;
    assign green_lamp   = result_reg.green_lamp;
    assign buzzer_drive = result_reg.buzzer_drive;
    assign walk_pending = result_reg.walk_pending;
    assign phase_now    = result_reg.phase_now;

endmodule

### hdl/tlps_cfg_regs.sv
module tlps_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output tlps_pkg::cfg_t     cfg
);

    tlps_pkg::cfg_t cfg_reg;
    tlps_pkg::cfg_t cfg_next;

    // decode register writes, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                tlps_pkg::REG_GREEN_TICKS:     cfg_next.green_ticks     = cfg_data;
                tlps_pkg::REG_YELLOW_TICKS:    cfg_next.yellow_ticks    = cfg_data;
                tlps_pkg::REG_RED_TICKS:       cfg_next.red_ticks       = cfg_data;
                tlps_pkg::REG_BUZZ_HALF_TICKS: cfg_next.buzz_half_ticks = cfg_data;
                tlps_pkg::REG_BUZZ_CYCLES:     cfg_next.buzz_cycles     = cfg_data[7:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_ticks     <= tlps_pkg::GREEN_TICKS_RST;
            cfg_reg.yellow_ticks    <= tlps_pkg::YELLOW_TICKS_RST;
            cfg_reg.red_ticks       <= tlps_pkg::RED_TICKS_RST;
            cfg_reg.buzz_half_ticks <= tlps_pkg::BUZZ_HALF_TICKS_RST;
            cfg_reg.buzz_cycles     <= tlps_pkg::BUZZ_CYCLES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/tlps_step_logic.sv
module tlps_step_logic (
    input  tlps_pkg::cfg_t     cfg,
    input  tlps_pkg::state_t   state,
    input  logic               button_down,
    output tlps_pkg::state_t   state_next,
    output tlps_pkg::result_t  result
);

    logic [2:0]  ph;
    logic [15:0] tick_inc;
    logic [15:0] timed_len;
    logic [15:0] half_len;
    logic [8:0]  half_inc;
    logic [8:0]  blink_limit;
    logic        on_half;

    always_comb
    begin
        // unused phase codes fall back to green1
        ph = (state.phase > tlps_pkg::PH_GREEN2) ? tlps_pkg::PH_GREEN1 : state.phase;

        tick_inc    = state.tick_count + 16'd1;
        half_inc    = state.half_count + 9'd1;
        half_len    = tlps_pkg::at_least_one16(cfg.buzz_half_ticks);
        blink_limit = {tlps_pkg::at_least_one8(cfg.buzz_cycles), 1'b0};
        on_half     = ~state.half_count[0];

        // length of the current timed phase
        case (ph)
            tlps_pkg::PH_YELRED,
            tlps_pkg::PH_YELLOW: timed_len = tlps_pkg::at_least_one16(cfg.yellow_ticks);
            tlps_pkg::PH_RED:    timed_len = tlps_pkg::at_least_one16(cfg.red_ticks);
            default:             timed_len = tlps_pkg::at_least_one16(cfg.green_ticks);
        endcase

        state_next = state;
        result     = '0;
        result.phase_now = ph;

        if (ph == tlps_pkg::PH_PED)
        begin
            // pedestrian blink, button ignored
            result.red_lamp     = 1'b1;
            result.green_lamp   = on_half;
            result.buzzer_drive = on_half;
            state_next.tick_count = tick_inc;
            if (tick_inc >= half_len)
            begin
                state_next.tick_count = '0;
                state_next.half_count = half_inc;
                if (half_inc >= blink_limit)
                begin
                    state_next.half_count = '0;
                    state_next.request    = 1'b0;
                    state_next.phase      = tlps_pkg::PH_YELLOW;
                end
            end
        end
        else
        begin
            // lamp drive for the timed phases
            case (ph)
                tlps_pkg::PH_YELRED:
                begin
                    result.yellow_lamp = 1'b1;
                    result.red_lamp    = 1'b1;
                end
                tlps_pkg::PH_RED:    result.red_lamp    = 1'b1;
                tlps_pkg::PH_YELLOW: result.yellow_lamp = 1'b1;
                default:             result.green_lamp  = 1'b1;
            endcase

            // press edge latches a walk request
            if (button_down && !state.button_was_down)
            begin
                state_next.request = 1'b1;
            end
            state_next.button_was_down = button_down;

            state_next.tick_count = tick_inc;
            state_next.phase      = ph;
            if (tick_inc >= timed_len)
            begin
                state_next.tick_count = '0;
                state_next.half_count = '0;
                case (ph)
                    tlps_pkg::PH_RED:
                        state_next.phase = state_next.request ? tlps_pkg::PH_PED
                                                              : tlps_pkg::PH_YELLOW;
                    tlps_pkg::PH_GREEN2: state_next.phase = tlps_pkg::PH_GREEN1;
                    default:             state_next.phase = ph + 3'd1;
                endcase
            end
        end

        result.walk_pending = state_next.request;
    end

endmodule
